### hdl/ihc_pkg.sv
// Shared types, constants and the byte-wide CRC-16 update for the image header check.
// No dependencies; every other file in hdl imports this package.
package ihc_pkg;

  localparam int HEADER_BYTES = 18;
  localparam int CRC_SPAN     = 16;
  localparam int LENGTH_FIRST = 2;
  localparam int WORD_FIRST   = 6;
  localparam int NUM_WORDS    = 6;
  localparam int IDX_W        = 5;
  localparam int WORD_IDX_W   = 3;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] MAX_CHANNELS = 16'd4;
  localparam logic [7:0]  MAGIC_0      = 8'h61;  // 'a'
  localparam logic [7:0]  MAGIC_1      = 8'h62;  // 'b'
  localparam logic [7:0]  SIZE_OVERHEAD_RESET = 8'd18;

  // Word slots in header order; the last one holds the stored CRC
  localparam logic [WORD_IDX_W-1:0] W_DEPTH    = 3'd0;
  localparam logic [WORD_IDX_W-1:0] W_CHANNELS = 3'd1;
  localparam logic [WORD_IDX_W-1:0] W_HEIGHT   = 3'd2;
  localparam logic [WORD_IDX_W-1:0] W_WIDTH    = 3'd3;
  localparam logic [WORD_IDX_W-1:0] W_OP       = 3'd4;
  localparam logic [WORD_IDX_W-1:0] W_CRC      = 3'd5;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_req;
    logic [31:0] buffer_size;
  } in_item_t;

  typedef struct packed {
    logic        header_ok;
    logic        size_ok;
    logic        crc_ok;
    logic [31:0] payload_length;
    logic [15:0] depth_field;
    logic [15:0] channels;
    logic [15:0] height;
    logic [15:0] width;
    logic [15:0] op_word;
  } result_t;

  // One byte through the CRC, MSB first, no reflection
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/ihc_in_stage.sv
// Input register for the image header check: holds one byte request and its flags.
// Depends on ihc_pkg.
module ihc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ihc_pkg::in_item_t in_item,
  input  logic              blocked,
  output logic              s1_valid,
  output ihc_pkg::in_item_t s1_item
);
  import ihc_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r, s1_item_nxt;

  // Hold while the parser cannot take the registered request
  assign in_stall = s1_valid_r & blocked;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
      s1_item_nxt  = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

### hdl/ihc_parser.sv
// Header parser: byte counter, running CRC, field capture and the final checks.
// Depends on ihc_pkg.
module ihc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  ihc_pkg::in_item_t item,
  input  logic [7:0]        size_overhead,
  output logic              res_load,
  output ihc_pkg::result_t  res
);
  import ihc_pkg::*;

  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             magic_r, magic_nxt;
  logic [31:0]      length_r, length_nxt;
  logic [15:0]      words_r [NUM_WORDS];
  logic [15:0]      words_nxt [NUM_WORDS];
  logic [31:0]      size_r, size_nxt;

  logic [IDX_W-1:0]      idx;
  logic                  active;
  logic [IDX_W-1:0]      word_off;
  logic [WORD_IDX_W-1:0] widx;
  logic [32:0]           size_sum;
  logic                  crc_ok, hdr_ok;

  // Advance the state on each accepted byte; a start drops any partial header
  always_comb begin
    byte_index_nxt = byte_index_r;
    crc_nxt        = crc_r;
    magic_nxt      = magic_r;
    length_nxt     = length_r;
    size_nxt       = size_r;
    for (int k = 0; k < NUM_WORDS; k++) begin
      words_nxt[k] = words_r[k];
    end
    idx      = byte_index_r;
    active   = 1'b0;
    word_off = '0;
    widx     = '0;
    res_load = 1'b0;
    if (fire) begin
      if (item.start_req) begin
        idx        = '0;
        crc_nxt    = '0;
        magic_nxt  = 1'b0;
        length_nxt = '0;
        size_nxt   = item.buffer_size;
        for (int k = 0; k < NUM_WORDS; k++) begin
          words_nxt[k] = '0;
        end
        active = 1'b1;
      end else begin
        active = (byte_index_r < IDX_W'(HEADER_BYTES));
      end
    end
    if (active) begin
      if (idx < IDX_W'(CRC_SPAN)) begin
        crc_nxt = crc16_byte(crc_nxt, item.data_byte);
      end
      if (idx == '0) begin
        magic_nxt = (item.data_byte == MAGIC_0);
      end else if (idx == IDX_W'(1)) begin
        magic_nxt = magic_nxt & (item.data_byte == MAGIC_1);
      end else if (idx < IDX_W'(WORD_FIRST)) begin
        length_nxt = {length_nxt[23:0], item.data_byte};
      end else begin
        word_off = idx - IDX_W'(WORD_FIRST);
        widx     = word_off[WORD_IDX_W:1];
        words_nxt[widx] = {words_nxt[widx][7:0], item.data_byte};
      end
      byte_index_nxt = idx + IDX_W'(1);
      res_load       = (idx == IDX_W'(HEADER_BYTES - 1));
    end
  end

  // Form the checks from the completed header
  always_comb begin
    size_sum = {1'b0, length_nxt} + {25'd0, size_overhead};
    crc_ok   = (words_nxt[W_CRC] == crc_nxt);
    hdr_ok   = magic_nxt && (length_nxt != '0) &&
               (words_nxt[W_DEPTH] != '0) && (words_nxt[W_CHANNELS] != '0) &&
               (words_nxt[W_CHANNELS] <= MAX_CHANNELS) &&
               (words_nxt[W_HEIGHT] != '0) && (words_nxt[W_WIDTH] != '0) && crc_ok;
    res.header_ok      = hdr_ok;
    res.size_ok        = hdr_ok && (size_sum == {1'b0, size_nxt});
    res.crc_ok         = crc_ok;
    res.payload_length = length_nxt;
    res.depth_field    = words_nxt[W_DEPTH];
    res.channels       = words_nxt[W_CHANNELS];
    res.height         = words_nxt[W_HEIGHT];
    res.width          = words_nxt[W_WIDTH];
    res.op_word        = words_nxt[W_OP];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= IDX_W'(HEADER_BYTES);
      crc_r        <= '0;
      magic_r      <= 1'b0;
      length_r     <= '0;
      size_r       <= '0;
      for (int k = 0; k < NUM_WORDS; k++) begin
        words_r[k] <= '0;
      end
    end else begin
      byte_index_r <= byte_index_nxt;
      crc_r        <= crc_nxt;
      magic_r      <= magic_nxt;
      length_r     <= length_nxt;
      size_r       <= size_nxt;
      for (int k = 0; k < NUM_WORDS; k++) begin
        words_r[k] <= words_nxt[k];
      end
    end
  end

endmodule

### hdl/ihc_out_reg.sv
// Result register for the image header check: holds one result until it is taken.
// Depends on ihc_pkg.
module ihc_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_load,
  input  ihc_pkg::result_t res,
  output logic             blocked,
  output logic             out_valid,
  input  logic             out_stall,
  output ihc_pkg::result_t out_res
);
  import ihc_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;

  // A held result that is not taken blocks the parser
  assign blocked = out_valid_r & out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    res_nxt       = res_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

### hdl/image_header_check_top.sv
// Image header check: one header byte per request, one result after the eighteenth byte.
// The last byte of a header passes the input register, then the parser into the result
// register, which raises out_valid. One byte per cycle while in_stall is low.
// Reset (rst_n low, synchronous): parser idle until a start byte, result register empty,
// size overhead back to 18. Uses ihc_pkg, ihc_in_stage, ihc_parser, ihc_out_reg.
module image_header_check_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_req,
  input  logic [31:0] in_buffer_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_header_ok,
  output logic        out_size_ok,
  output logic        out_crc_ok,
  output logic [31:0] out_payload_length,
  output logic [15:0] out_depth_field,
  output logic [15:0] out_channels,
  output logic [15:0] out_height,
  output logic [15:0] out_width,
  output logic [15:0] out_op_word,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import ihc_pkg::*;

  logic [7:0] overhead_r, overhead_nxt;
  in_item_t   in_item, s1_item;
  logic       s1_valid, blocked, fire, res_load;
  result_t    res, out_res;

  // Configuration register
  assign overhead_nxt = cfg_wr_en ? cfg_wr_data : overhead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overhead_r <= SIZE_OVERHEAD_RESET;
    end else begin
      overhead_r <= overhead_nxt;
    end
  end

  assign in_item.data_byte   = in_data_byte;
  assign in_item.start_req   = in_start_req;
  assign in_item.buffer_size = in_buffer_size;

  ihc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .blocked  (blocked),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Move the registered request into the parser unless the result side is full
  assign fire = s1_valid & ~blocked;

  ihc_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (s1_item),
    .size_overhead (overhead_r),
    .res_load      (res_load),
    .res           (res)
  );

  ihc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .blocked   (blocked),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_header_ok      = out_res.header_ok;
  assign out_size_ok        = out_res.size_ok;
  assign out_crc_ok         = out_res.crc_ok;
  assign out_payload_length = out_res.payload_length;
  assign out_depth_field    = out_res.depth_field;
  assign out_channels       = out_res.channels;
  assign out_height         = out_res.height;
  assign out_width          = out_res.width;
  assign out_op_word        = out_res.op_word;

endmodule

### dv/ihc_result_checker.sv
// Result checker for the image header check: byte-level header predictor and field compare.
// Depends on ihc_pkg for widths, magic bytes and word slots; also holds ihc_tb_pkg,
// the CRC step shared with the stimulus side of the testbench.
package ihc_tb_pkg;

  // Packed so that whole headers can be passed and returned by value
  typedef logic [17:0][7:0] hdr_bytes_t;

  // Advance the CRC-16 one byte, feeding the data bits in MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ ihc_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

module ihc_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_req,
  input  logic [31:0] in_buffer_size,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_header_ok,
  input  logic        out_size_ok,
  input  logic        out_crc_ok,
  input  logic [31:0] out_payload_length,
  input  logic [15:0] out_depth_field,
  input  logic [15:0] out_channels,
  input  logic [15:0] out_height,
  input  logic [15:0] out_width,
  input  logic [15:0] out_op_word,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output int unsigned fail_count,
  output int unsigned pending_count
);
  import ihc_pkg::*;
  import ihc_tb_pkg::*;

  // Shadow of the parser state and the size overhead register
  logic [IDX_W-1:0] hdr_pos;
  logic [15:0]      crc_acc;
  logic             magic_seen;
  logic [31:0]      len_acc;
  logic [15:0]      words [NUM_WORDS];
  logic [31:0]      buf_size;
  logic [7:0]       overhead;

  result_t          decoded_headers [$];

  // Drop any partial header
  task automatic clear_fields();
    crc_acc    = '0;
    magic_seen = 1'b0;
    len_acc    = '0;
    foreach (words[k]) begin
      words[k] = '0;
    end
  endtask

  // Take one accepted byte; queue the decoded header when the last byte lands
  task automatic absorb_byte(input logic [7:0] b, input logic s, input logic [31:0] sz);
    int          w;
    logic [32:0] total;
    logic        crc_match;
    result_t     r;
    if (s) begin
      hdr_pos  = '0;
      buf_size = sz;
      clear_fields();
    end else if (int'(hdr_pos) >= HEADER_BYTES) begin
      return;
    end
    if (int'(hdr_pos) < CRC_SPAN) begin
      crc_acc = crc16_step(crc_acc, b);
    end
    if (int'(hdr_pos) == 0) begin
      magic_seen = (b == MAGIC_0);
    end else if (int'(hdr_pos) == 1) begin
      magic_seen = magic_seen && (b == MAGIC_1);
    end else if (int'(hdr_pos) < WORD_FIRST) begin
      len_acc = {len_acc[23:0], b};
    end else begin
      w = (int'(hdr_pos) - WORD_FIRST) >> 1;
      if (w < NUM_WORDS) begin
        words[w] = {words[w][7:0], b};
      end
    end
    hdr_pos = hdr_pos + 5'd1;
    if (int'(hdr_pos) != HEADER_BYTES) begin
      return;
    end
    // Form the verdicts; the size sum is 33 bits wide so it never wraps
    crc_match = (words[W_CRC] == crc_acc);
    total     = {1'b0, len_acc} + {25'd0, overhead};
    r.crc_ok    = crc_match;
    r.header_ok = magic_seen && (len_acc != 0) && (words[W_DEPTH] != 0) &&
                  (words[W_CHANNELS] != 0) && (words[W_CHANNELS] <= MAX_CHANNELS) &&
                  (words[W_HEIGHT] != 0) && (words[W_WIDTH] != 0) && crc_match;
    r.size_ok        = r.header_ok && (total == {1'b0, buf_size});
    r.payload_length = len_acc;
    r.depth_field    = words[W_DEPTH];
    r.channels       = words[W_CHANNELS];
    r.height         = words[W_HEIGHT];
    r.width          = words[W_WIDTH];
    r.op_word        = words[W_OP];
    decoded_headers.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos  = IDX_W'(HEADER_BYTES);
      buf_size = '0;
      overhead = SIZE_OVERHEAD_RESET;
      clear_fields();
      decoded_headers.delete();
    end else begin
      // Compare each accepted result with the oldest decoded header
      if (out_valid && !out_stall) begin
        if (decoded_headers.size() == 0) begin
          $error("result with no header pending: payload_length 0x%0h", out_payload_length);
          fail_count++;
        end else begin
          result_t want;
          want = decoded_headers.pop_front();
          check_field("header_ok", 32'(want.header_ok), 32'(out_header_ok));
          check_field("size_ok", 32'(want.size_ok), 32'(out_size_ok));
          check_field("crc_ok", 32'(want.crc_ok), 32'(out_crc_ok));
          check_field("payload_length", want.payload_length, out_payload_length);
          check_field("depth_field", 32'(want.depth_field), 32'(out_depth_field));
          check_field("channels", 32'(want.channels), 32'(out_channels));
          check_field("height", 32'(want.height), 32'(out_height));
          check_field("width", 32'(want.width), 32'(out_width));
          check_field("op_word", 32'(want.op_word), 32'(out_op_word));
        end
      end
      if (in_valid && !in_stall) begin
        absorb_byte(in_data_byte, in_start_req, in_buffer_size);
      end
      if (cfg_wr_en) begin
        overhead = cfg_wr_data;
      end
    end
    pending_count = decoded_headers.size();
  end

endmodule

### dv/image_header_check_top_tb.sv
// Testbench top for image_header_check_top: clock, reset, header byte stimulus, result
// stall, overhead register writes and the verdict. Depends on ihc_pkg and ihc_result_checker.
module image_header_check_top_tb;
  import ihc_pkg::*;
  import ihc_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 120;
  localparam int NUM_PHASES    = 5;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte   = '0;
  logic        in_start_req   = 1'b0;
  logic [31:0] in_buffer_size = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        out_header_ok;
  logic        out_size_ok;
  logic        out_crc_ok;
  logic [31:0] out_payload_length;
  logic [15:0] out_depth_field;
  logic [15:0] out_channels;
  logic [15:0] out_height;
  logic [15:0] out_width;
  logic [15:0] out_op_word;
  logic        cfg_wr_en      = 1'b0;
  logic [7:0]  cfg_wr_data    = '0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_cnt      = 0;
  logic        quiet_phase    = 1'b0;
  logic        out_took       = 1'b0;
  int          hold_cnt       = 0;
  logic [7:0]  overhead_now   = SIZE_OVERHEAD_RESET;
  int          header_bytes   = 0;

  image_header_check_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_req       (in_start_req),
    .in_buffer_size     (in_buffer_size),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_header_ok      (out_header_ok),
    .out_size_ok        (out_size_ok),
    .out_crc_ok         (out_crc_ok),
    .out_payload_length (out_payload_length),
    .out_depth_field    (out_depth_field),
    .out_channels       (out_channels),
    .out_height         (out_height),
    .out_width          (out_width),
    .out_op_word        (out_op_word),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  ihc_result_checker u_result_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_req       (in_start_req),
    .in_buffer_size     (in_buffer_size),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_header_ok      (out_header_ok),
    .out_size_ok        (out_size_ok),
    .out_crc_ok         (out_crc_ok),
    .out_payload_length (out_payload_length),
    .out_depth_field    (out_depth_field),
    .out_channels       (out_channels),
    .out_height         (out_height),
    .out_width          (out_width),
    .out_op_word        (out_op_word),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Draw a fresh result stall after every accepted result; the count runs down while idle too
  always @(posedge clk) begin
    out_took <= out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (out_took) begin
      hold_cnt = quiet_phase ? 0 : int'($urandom_range(0, 9));
    end
    out_stall <= (hold_cnt != 0);
    if (hold_cnt != 0) begin
      hold_cnt--;
    end
  end

  // Present one byte request after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] d, input logic s, input logic [31:0] sz);
    int gap;
    gap = quiet_phase ? 0 : int'($urandom_range(0, 9));
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= d;
    in_start_req   <= s;
    in_buffer_size <= sz;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Lower valid, let every decoded header come out, then let the pipeline settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_count != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_overhead(input logic [7:0] v);
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= v;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    overhead_now = v;
  endtask

  // Build a big-endian header, stamp its CRC (flipped on request) and send the first
  // cut bytes; the buffer size rides on the start byte, other bytes carry noise there
  task automatic send_header(input logic [7:0] m0, input logic [7:0] m1,
                             input logic [31:0] len, input logic [15:0] depth,
                             input logic [15:0] ch, input logic [15:0] h,
                             input logic [15:0] w, input logic [15:0] op,
                             input logic crc_good, input logic [31:0] sz, input int cut);
    hdr_bytes_t  hb;
    logic [15:0] c;
    hb[0] = m0;
    hb[1] = m1;
    {hb[2], hb[3], hb[4], hb[5]} = len;
    {hb[6], hb[7]}   = depth;
    {hb[8], hb[9]}   = ch;
    {hb[10], hb[11]} = h;
    {hb[12], hb[13]} = w;
    {hb[14], hb[15]} = op;
    c = '0;
    for (int k = 0; k < CRC_SPAN; k++) begin
      c = crc16_step(c, hb[k]);
    end
    if (!crc_good) begin
      c = c ^ (16'd1 << $urandom_range(0, 15));
    end
    {hb[16], hb[17]} = c;
    for (int k = 0; k < cut; k++) begin
      send_byte(hb[k], k == 0, (k == 0) ? sz : $urandom());
    end
    header_bytes += cut;
  endtask

  // Mostly well-formed headers with random content, some broken or plain noise
  task automatic random_header();
    logic [7:0]  m0;
    logic [7:0]  m1;
    logic [31:0] len;
    logic [31:0] sz;
    logic [15:0] depth;
    logic [15:0] ch;
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] op;
    logic        crc_good;
    int          cut;
    quiet_phase <= ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 14) == 0) begin
      for (int k = 0; k < HEADER_BYTES; k++) begin
        send_byte(8'($urandom()), k == 0, $urandom());
      end
      header_bytes += HEADER_BYTES;
      return;
    end
    m0 = MAGIC_0;
    m1 = MAGIC_1;
    case ($urandom_range(0, 19))
      0: m0 = 8'($urandom());
      1: m1 = 8'($urandom());
      default: ;
    endcase
    len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom();
    depth = 16'($urandom());
    ch    = 16'($urandom_range(1, 4));
    h     = 16'($urandom());
    w     = 16'($urandom());
    op    = 16'($urandom());
    // Knock out one of the checked fields now and then
    case ($urandom_range(0, 15))
      0: len   = '0;
      1: depth = '0;
      2: ch    = '0;
      3: ch    = 16'($urandom());
      4: ch    = 16'($urandom_range(5, 8));
      5: h     = '0;
      6: w     = '0;
      default: ;
    endcase
    crc_good = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 7))
      0: sz = $urandom();
      1: sz = len + overhead_now + 32'd1;
      2: sz = len + overhead_now - 32'd1;
      default: sz = len + overhead_now;
    endcase
    cut = ($urandom_range(0, 11) == 0) ? int'($urandom_range(1, 17)) : HEADER_BYTES;
    send_header(m0, m1, len, depth, ch, h, w, op, crc_good, sz, cut);
    // Trailing bytes go nowhere after a full header but extend a cut one
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom()), 1'b0, $urandom());
    end
  endtask

  initial begin
    logic [7:0] phase_cfg;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Bytes before any start are ignored
    send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
    send_byte(8'h00, 1'b0, 32'h0000_0000);
    // Clean header at reset overhead, size matches
    send_header(MAGIC_0, MAGIC_1, 32'd100, 16'd8, MAX_CHANNELS, 16'd1, 16'd1, 16'd0,
                1'b1, 32'd118, HEADER_BYTES);
    // Field maxima; the size would match only if the sum wrapped at 32 bits
    send_header(MAGIC_0, MAGIC_1, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 1'b1, 32'h0000_0011, HEADER_BYTES);
    // Too many channels, zero length with a matching size, bad magic, bad CRC
    send_header(MAGIC_0, MAGIC_1, 32'd64, 16'd1, 16'd5, 16'd2, 16'd2, 16'd3,
                1'b1, 32'd82, HEADER_BYTES);
    send_header(MAGIC_0, MAGIC_1, 32'd0, 16'd1, 16'd1, 16'd2, 16'd2, 16'd3,
                1'b1, 32'd18, HEADER_BYTES);
    send_header(MAGIC_1, MAGIC_1, 32'd10, 16'd1, 16'd3, 16'd2, 16'd2, 16'd3,
                1'b1, 32'd28, HEADER_BYTES);
    send_header(MAGIC_0, MAGIC_0, 32'd10, 16'd1, 16'd3, 16'd2, 16'd2, 16'd3,
                1'b1, 32'd28, HEADER_BYTES);
    send_header(MAGIC_0, MAGIC_1, 32'd10, 16'd1, 16'd3, 16'd2, 16'd2, 16'd3,
                1'b0, 32'd28, HEADER_BYTES);
    // Zero channels; then a start in mid-header restarts the parse
    send_header(MAGIC_0, MAGIC_1, 32'd10, 16'd1, 16'd0, 16'd2, 16'd2, 16'd3,
                1'b1, 32'd28, HEADER_BYTES);
    send_header(MAGIC_0, MAGIC_1, 32'd77, 16'd4, 16'd2, 16'd9, 16'd9, 16'd1,
                1'b1, 32'd95, 9);
    send_header(MAGIC_0, MAGIC_1, 32'd5, 16'd4, 16'd2, 16'd9, 16'd9, 16'd1,
                1'b1, 32'd23, HEADER_BYTES);
    send_byte(8'h61, 1'b0, 32'h0000_0017);

    // Hold the sender until everything is out, then try the overhead extremes
    wait_for_results();
    write_overhead(8'hFF);
    send_header(MAGIC_0, MAGIC_1, 32'hFFFF_FF00, 16'd1, 16'd4, 16'd1, 16'd1, 16'd0,
                1'b1, 32'hFFFF_FFFF, HEADER_BYTES);
    send_header(MAGIC_0, MAGIC_1, 32'hFFFF_FFFF, 16'd1, 16'd4, 16'd1, 16'd1, 16'd0,
                1'b1, 32'hFFFF_FFFF, HEADER_BYTES);
    wait_for_results();
    write_overhead(8'h00);
    send_header(MAGIC_0, MAGIC_1, 32'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0,
                1'b1, 32'd1, HEADER_BYTES);

    // Random phases, each with its own overhead setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_cfg = SIZE_OVERHEAD_RESET;
        1: phase_cfg = 8'hFF;
        2: phase_cfg = 8'h00;
        default: phase_cfg = 8'($urandom());
      endcase
      wait_for_results();
      write_overhead(phase_cfg);
      header_bytes = 0;
      while (header_bytes < PHASE_BYTES) begin
        random_header();
        if ($urandom_range(0, 9) == 0) begin
          wait_for_results();
        end
      end
    end

    wait_for_results();
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
